// ===== sv/lpht_pkg.sv =====
// Shared types, constants and codes for the linear probe hash table unit.
package lpht_pkg;

    localparam int SLOTS_DEFAULT = 128;
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int ENTRY_BITS    = 8;
    localparam int Q_DEPTH       = 2;

    // One-round FNV-1a mix constants
    localparam logic [63:0] MIX_OFFSET = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] MIX_PRIME  = 64'h0000_0100_0000_01B3;

    typedef enum logic [1:0] {
        ACT_LOOKUP  = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NEXT    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROBE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        action_t                      action;
        logic signed [KEY_BITS-1:0]   key;
        logic        [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                      status;
        logic signed [KEY_BITS-1:0]   result_key;
        logic        [VALUE_BITS-1:0] result_value;
        logic        [ENTRY_BITS-1:0] entry_total;
    } rsp_t;

    typedef struct packed {
        action_t                      action;
        logic        [KEY_BITS-1:0]   key;
        logic        [VALUE_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_entry_t;

endpackage

// ===== sv/linear_probe_hash_table_unit.sv =====
// Top level of the linear probe hash table unit.
//
// Keyed store of SLOTS entries (a power of two) with open addressing and
// linear probing. Each request word carries an action: lookup, insert or
// update, iterator restart, or iterator next; each one produces exactly one
// response word with a status, the key and value where the action returns
// them, and the entry count after the action. The home slot is the low bits
// of (offset xor sign-extended key) times prime, from a one-round FNV-1a mix.
// A probe gives up after visiting every slot once and reports not found, or
// table full on insert. There is no delete. Valid marks are cleared by reset
// at once; no clearing pass is needed and the unit takes requests right after
// reset. A request passes through the front stage register and the command
// queue; the probe engine then dispatches it and examines one slot at a time,
// since each slot costs one read of the slot memory. A lookup or insert
// examines its home slot and one more slot per extra probe; iterator next
// also examines each empty slot it skips; restart and an ended iteration read
// no slot. Results sit in an output register, so the engine keeps working
// while a finished word waits for the downstream side to drop stall.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SLOT_BITS = $clog2(SLOTS);

    // Front stage to queue
    logic                 push_valid;
    logic                 push_full;
    cmd_t                 push_cmd;
    logic [SLOT_BITS-1:0] push_home;

    // Queue to probe engine
    logic                 head_valid;
    logic                 pop;
    cmd_t                 head_cmd;
    logic [SLOT_BITS-1:0] head_home;

    // Hash the key and hold the command until the queue has room
    lpht_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_cmd   (push_cmd),
        .push_home  (push_home)
    );

    // Decouple request intake from the probe engine
    lpht_cmd_queue #(
        .SLOTS (SLOTS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_cmd   (push_cmd),
        .push_home  (push_home),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_home  (head_home)
    );

    // Walk the slots, update the store and register the response word
    lpht_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_home  (head_home),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

// ===== sv/lpht_front.sv =====
// Front stage: accept request words, compute the home slot, hand commands to the queue.
module lpht_front
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  req_t                          req,
    output logic                          push_valid,
    input  logic                          push_full,
    output cmd_t                          push_cmd,
    output logic [$clog2(SLOTS)-1:0]      push_home
);

    localparam int SLOT_BITS = $clog2(SLOTS);

    logic                 front_valid_reg;
    logic                 front_valid_next;
    cmd_t                 cmd_reg;
    logic [SLOT_BITS-1:0] home_reg;

    logic [63:0]          key_ext;
    logic [SLOT_BITS-1:0] mix_lo;
    logic [SLOT_BITS-1:0] prime_lo;
    logic [SLOT_BITS-1:0] home;
    logic                 take;
    logic                 push;

    // Only the low slot bits of the 64-bit product matter, and they depend
    // only on the low slot bits of both operands.
    assign key_ext  = 64'(req.key);
    assign mix_lo   = SLOT_BITS'(MIX_OFFSET ^ key_ext);
    assign prime_lo = SLOT_BITS'(MIX_PRIME);
    assign home     = mix_lo * prime_lo;

    assign push      = front_valid_reg && !push_full;
    assign req_stall = front_valid_reg && push_full;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.action <= req.action;
            cmd_reg.key    <= req.key;
            cmd_reg.value  <= req.value;
            home_reg       <= home;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_cmd   = cmd_reg;
    assign push_home  = home_reg;

endmodule

// ===== sv/lpht_cmd_queue.sv =====
// Short command queue between the front stage and the probe engine.
module lpht_cmd_queue
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_valid,
    output logic                          push_full,
    input  cmd_t                          push_cmd,
    input  logic [$clog2(SLOTS)-1:0]      push_home,
    output logic                          head_valid,
    input  logic                          pop,
    output cmd_t                          head_cmd,
    output logic [$clog2(SLOTS)-1:0]      head_home
);

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(Q_DEPTH + 1);

    cmd_t                 cmd_reg  [Q_DEPTH];
    logic [SLOT_BITS-1:0] home_reg [Q_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [FILL_BITS-1:0] fill_reg;
    logic [FILL_BITS-1:0] fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_full  = (fill_reg == FILL_BITS'(Q_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign do_push    = push_valid && !push_full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_reg[wr_ptr_reg]  <= push_cmd;
            home_reg[wr_ptr_reg] <= push_home;
        end
    end

    assign head_cmd  = cmd_reg[rd_ptr_reg];
    assign head_home = home_reg[rd_ptr_reg];

endmodule

// ===== sv/lpht_back.sv =====
// Probe engine: slot memory, valid marks, entry count, iterator and result register.
module lpht_back
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    output logic                          pop,
    input  cmd_t                          head_cmd,
    input  logic [$clog2(SLOTS)-1:0]      head_home,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output rsp_t                          rsp
);

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CUR_BITS  = $clog2(SLOTS + 1);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);
    localparam logic [CUR_BITS-1:0]  CUR_END   = CUR_BITS'(SLOTS);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [SLOTS-1:0]     valid_reg;
    logic [CUR_BITS-1:0]  count_reg;
    logic [CUR_BITS-1:0]  count_next;
    logic [CUR_BITS-1:0]  cursor_reg;
    logic [CUR_BITS-1:0]  cursor_next;
    logic [SLOT_BITS-1:0] idx_reg;
    logic [SLOT_BITS-1:0] idx_next;
    logic [SLOT_BITS-1:0] probe_reg;
    logic [SLOT_BITS-1:0] probe_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    rsp_t                 res_reg;
    rsp_t                 res_next;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    slot_entry_t          mem [SLOTS];
    slot_entry_t          rd_data_reg;
    slot_entry_t          wr_entry;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic                 set_valid;

    logic                 out_free;
    logic                 dispatch_ok;
    logic                 finish;
    logic                 at_end;
    logic [SLOT_BITS-1:0] cur_addr;

    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign dispatch_ok = (state_reg == BK_IDLE) || ((state_reg == BK_EMIT) && out_free);
    assign at_end      = (cursor_reg == CUR_END);
    assign cur_addr    = cursor_reg[SLOT_BITS-1:0];
    assign wr_entry    = '{key: cmd_reg.key, value: cmd_reg.value};

    // Datapath and handshake outputs
    always_comb
    begin
        pop            = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        set_valid      = 1'b0;
        finish         = 1'b0;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if ((state_reg == BK_EMIT) && out_free)
        begin
            rsp_next             = res_reg;
            rsp_next.entry_total = ENTRY_BITS'(count_reg);
            rsp_valid_next       = 1'b1;
        end

        if (dispatch_ok && head_valid)
        begin
            pop      = 1'b1;
            cmd_next = head_cmd;
            res_next = '{status: ST_OK, result_key: '0, result_value: '0, entry_total: '0};
            unique case (head_cmd.action)
                ACT_LOOKUP, ACT_INSERT:
                begin
                    rd_addr    = head_home;
                    idx_next   = head_home;
                    probe_next = '0;
                end
                ACT_RESTART:
                begin
                    cursor_next = '0;
                end
                ACT_NEXT:
                begin
                    if (at_end)
                    begin
                        res_next.status = ST_END;
                    end
                    else
                    begin
                        rd_addr = cur_addr;
                    end
                end
                default:
                begin
                    rd_addr = idx_reg;
                end
            endcase
        end

        unique case (state_reg)
            BK_PROBE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    finish = 1'b1;
                    if (cmd_reg.action == ACT_INSERT)
                    begin
                        wr_en           = 1'b1;
                        set_valid       = 1'b1;
                        count_next      = count_reg + CUR_BITS'(1);
                        res_next.status = ST_OK;
                    end
                    else
                    begin
                        res_next.status = ST_NOT_FOUND;
                    end
                end
                else if (rd_data_reg.key == cmd_reg.key)
                begin
                    finish          = 1'b1;
                    res_next.status = ST_OK;
                    if (cmd_reg.action == ACT_INSERT)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        res_next.result_value = rd_data_reg.value;
                    end
                end
                else if (probe_reg == LAST_SLOT)
                begin
                    finish          = 1'b1;
                    res_next.status = (cmd_reg.action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_BITS'(1);
                    probe_next = probe_reg + SLOT_BITS'(1);
                    rd_addr    = idx_reg + SLOT_BITS'(1);
                end
            end
            BK_SCAN:
            begin
                cursor_next = cursor_reg + CUR_BITS'(1);
                if (valid_reg[cur_addr])
                begin
                    finish                = 1'b1;
                    res_next.status       = ST_OK;
                    res_next.result_key   = rd_data_reg.key;
                    res_next.result_value = rd_data_reg.value;
                end
                else if (cur_addr == LAST_SLOT)
                begin
                    finish          = 1'b1;
                    res_next.status = ST_END;
                end
                else
                begin
                    rd_addr = cur_addr + SLOT_BITS'(1);
                end
            end
            BK_IDLE, BK_EMIT:
            begin
                finish = 1'b0;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE, BK_EMIT:
            begin
                if ((state_reg == BK_EMIT) && !out_free)
                begin
                    state_next = BK_EMIT;
                end
                else if (head_valid)
                begin
                    unique case (head_cmd.action)
                        ACT_LOOKUP, ACT_INSERT: state_next = BK_PROBE;
                        ACT_RESTART:            state_next = BK_EMIT;
                        ACT_NEXT:               state_next = at_end ? BK_EMIT : BK_SCAN;
                        default:                state_next = BK_IDLE;
                    endcase
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_PROBE, BK_SCAN:
            begin
                state_next = finish ? BK_EMIT : state_reg;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
            if (set_valid)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    // Slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== verif/linear_probe_hash_table_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the linear probe hash table unit.
module linear_probe_hash_table_unit_test;
    import lpht_pkg::*;

    localparam int TABLE_SLOTS  = SLOTS_DEFAULT;
    // Longest stretch with no word moving on either side, enough for a full-table
    // probe stacked behind the queue and a receiver stall.
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Shadow of the table: predicts each response word from the request
    // words in the order they were accepted, and checks words as they leave.
    class lpht_scoreboard;
        bit                    slot_used [TABLE_SLOTS];
        logic [KEY_BITS-1:0]   slot_key  [TABLE_SLOTS];
        logic [VALUE_BITS-1:0] slot_val  [TABLE_SLOTS];
        int unsigned           filled;
        int unsigned           cursor;
        rsp_t                  expected_q [$];
        int                    errors;
        int                    checked;
        int                    status_seen [4];

        function new();
            filled  = 0;
            cursor  = 0;
            errors  = 0;
            checked = 0;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function int unsigned home_slot(logic [KEY_BITS-1:0] k);
            logic [63:0] h;
            h = MIX_OFFSET ^ {{(64-KEY_BITS){k[KEY_BITS-1]}}, k};
            h = h * MIX_PRIME;
            return int'(h & 64'(TABLE_SLOTS - 1));
        endfunction

        function void note_request(req_t w);
            rsp_t        e;
            int unsigned idx;
            int unsigned n;
            bit          done;
            e    = '0;
            done = 1'b0;
            case (w.action)
                ACT_LOOKUP, ACT_INSERT:
                begin
                    idx = home_slot(w.key);
                    if (w.action == ACT_LOOKUP)
                        e.status = ST_NOT_FOUND;
                    else
                        e.status = ST_FULL;
                    for (n = 0; n < TABLE_SLOTS && !done; n++)
                    begin
                        if (!slot_used[idx])
                        begin
                            if (w.action == ACT_INSERT)
                            begin
                                slot_used[idx] = 1'b1;
                                slot_key[idx]  = w.key;
                                slot_val[idx]  = w.value;
                                filled++;
                                e.status = ST_OK;
                            end
                            done = 1'b1;
                        end
                        else if (slot_key[idx] == w.key)
                        begin
                            if (w.action == ACT_INSERT)
                                slot_val[idx] = w.value;
                            else
                                e.result_value = slot_val[idx];
                            e.status = ST_OK;
                            done     = 1'b1;
                        end
                        else
                        begin
                            idx = (idx + 1) % TABLE_SLOTS;
                        end
                    end
                end
                ACT_RESTART:
                begin
                    cursor = 0;
                end
                default:
                begin
                    e.status = ST_END;
                    while (cursor < TABLE_SLOTS && !done)
                    begin
                        idx = cursor;
                        cursor++;
                        if (slot_used[idx])
                        begin
                            e.status       = ST_OK;
                            e.result_key   = slot_key[idx];
                            e.result_value = slot_val[idx];
                            done           = 1'b1;
                        end
                    end
                end
            endcase
            e.entry_total = ENTRY_BITS'(filled);
            expected_q.push_back(e);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t: response %0d: %s is %h, predicted %h",
                     $realtime, checked, what, got, want);
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unrequested word, status", got.status, 0);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.result_key !== want.result_key)
                report_mismatch("result_key", got.result_key, want.result_key);
            if (got.result_value !== want.result_value)
                report_mismatch("result_value", got.result_value, want.result_value);
            if (got.entry_total !== want.entry_total)
                report_mismatch("entry_total", got.entry_total, want.entry_total);
        endtask
    endclass

    lpht_scoreboard      sb;
    logic [KEY_BITS-1:0] used_keys [$];
    int                  burst_left;
    int                  words_sent;
    int                  idle_cycles;
    int                  stall_mode;
    int                  stall_phase = 0;
    int                  stall_hold  = 0;

    linear_probe_hash_table_unit #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver stall pattern: stretches with no stall, sparse random stall,
    // and long toggling holds, each lasting a while.
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_phase = $urandom_range(16, 160);
        end
        stall_phase--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_hold == 0)
                begin
                    stall_hold = $urandom_range(1, 8);
                    rsp_stall <= ~rsp_stall;
                end
                else
                begin
                    stall_hold--;
                end
            end
        endcase
    end

    // Check every response word as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // Drop the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one request word and hold it until taken. Bursts of random
    // length, separated by random gaps, with an occasional long gap-free run.
    task automatic send_word(input req_t w);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 300);
            else
            begin
                burst_left = $urandom_range(1, 24);
                repeat ($urandom_range(1, 6))
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge clk);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(w);
        words_sent++;
    endtask

    task automatic send_op(action_t a, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
        req_t w;
        w.action = a;
        w.key    = k;
        w.value  = v;
        send_word(w);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Mostly keys already used, so lookups hit and inserts update; some
    // extreme keys; the rest fresh, which miss.
    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (used_keys.size() != 0 && r < 60)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (r < 70)
        begin
            case (r % 4)
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [KEY_BITS-1:0] key_for_slot(int unsigned slot);
        logic [KEY_BITS-1:0] k;
        k = $urandom();
        while (sb.home_slot(k) != slot)
            k = $urandom();
        return k;
    endfunction

    task automatic insert_key(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
        used_keys.push_back(k);
        send_op(ACT_INSERT, k, v);
    endtask

    task automatic insert_fresh();
        insert_key($urandom(), pick_value());
    endtask

    // Random traffic: iterator sweeps (restart, then a run of next with an
    // insert now and then), new inserts, updates, lookups, and lone
    // iterator words as noise.
    task automatic run_random(int count, int fresh_pct);
        int items;
        int r;
        int n;
        items = 0;
        while (items < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                send_op(ACT_RESTART, $urandom(), $urandom());
                n = $urandom_range(1, 48);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        insert_fresh();
                    else
                        send_op(ACT_NEXT, $urandom(), $urandom());
                end
                items += n + 1;
            end
            else
            begin
                if (r < 12 + fresh_pct)
                    insert_fresh();
                else if (r < 55)
                    send_op(ACT_INSERT, pick_key(), pick_value());
                else if (r < 92)
                    send_op(ACT_LOOKUP, pick_key(), $urandom());
                else if (r < 96)
                    send_op(ACT_NEXT, $urandom(), $urandom());
                else
                    send_op(ACT_RESTART, $urandom(), $urandom());
                items++;
            end
        end
    endtask

    initial
    begin
        logic [KEY_BITS-1:0] key_near_zero;
        logic [KEY_BITS-1:0] key_last_a;
        logic [KEY_BITS-1:0] key_last_b;

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_stall   = 1'b0;
        burst_left  = 0;
        words_sent  = 0;
        idle_cycles = 0;
        sb          = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Keys that share a home slot: one beside key zero, two on the last
        // slot so the second one wraps around to the start of the table.
        key_near_zero = key_for_slot(sb.home_slot(32'h0));
        key_last_a    = key_for_slot(TABLE_SLOTS - 1);
        key_last_b    = key_for_slot(TABLE_SLOTS - 1);

        // Directed: iterator on an empty table, miss on empty, extreme keys
        // and values, collisions and wrap, update, miss, iterator end held
        // until restart, then a full sweep.
        send_op(ACT_NEXT, $urandom(), $urandom());
        send_op(ACT_LOOKUP, 32'h0, $urandom());
        insert_key(32'h8000_0000, 32'h0000_0000);
        insert_key(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        insert_key(32'h0000_0000, 32'h5A5A_5A5A);
        insert_key(32'hFFFF_FFFF, 32'hA5A5_A5A5);
        insert_key(key_near_zero, $urandom());
        insert_key(key_last_a, $urandom());
        insert_key(key_last_b, $urandom());
        send_op(ACT_LOOKUP, 32'h8000_0000, $urandom());
        send_op(ACT_LOOKUP, key_near_zero, $urandom());
        send_op(ACT_LOOKUP, key_last_b, $urandom());
        send_op(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(ACT_LOOKUP, 32'h0000_0000, $urandom());
        send_op(ACT_LOOKUP, 32'h1234_5678, $urandom());
        send_op(ACT_NEXT, $urandom(), $urandom());
        send_op(ACT_RESTART, $urandom(), $urandom());
        repeat (8)
            send_op(ACT_NEXT, $urandom(), $urandom());

        // Random traffic on a partly filled table, then fill it, then random
        // traffic on the full table: long misses and refused inserts.
        run_random(650, 8);
        while (sb.filled < TABLE_SLOTS)
            insert_fresh();
        run_random(550, 8);

        @(negedge clk);
        req_valid <= 1'b0;

        // Wait for every predicted word, then watch for strays.
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d request words sent, %0d responses checked, table filled to %0d of %0d",
                 words_sent, sb.checked, sb.filled, TABLE_SLOTS);
        $display("statuses seen: ok %0d, not found %0d, full %0d, iteration end %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_END]);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
